[design/rotate_xor_string_hash_mod_defines.svh]
// assertion macros for the rotate-xor string hash checker
`ifndef ROTATE_XOR_STRING_HASH_MOD_DEFINES_SVH
`define ROTATE_XOR_STRING_HASH_MOD_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define RXH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rxh check failed: same-cycle rule");

// next-cycle implication, disabled while rst is high
`define RXH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rxh check failed: next-cycle rule");

`endif

[design/rxh_pkg.sv]
// shared types and constants for the rotate-xor string hash block
`default_nettype none

package rxh_pkg;

   localparam int CHAR_WIDTH  = 16;
   localparam int HASH_WIDTH  = 32;
   localparam int CAP_WIDTH   = 31;
   localparam int SHIFT_LEFT  = 5;
   localparam int SHIFT_RIGHT = 27;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(1024);

   // low CHAR_WIDTH bits of a character are absorbed
   localparam logic [HASH_WIDTH-1:0] CHAR_MASK =
      HASH_WIDTH'(64'hFFFF_FFFF >> (HASH_WIDTH - CHAR_WIDTH));

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef struct packed {
      logic [HASH_WIDTH-1:0] hash;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

[design/rotate_xor_string_hash_mod.sv]
// top level of the rotate-xor string hash with modulo by capacity minus one
//
// characters of a string enter last to first, one request per cycle, and fold
// into a 32-bit hash as (hash<<5) ^ (hash>>27) ^ char; the request marked last
// closes the string and yields one response, hash mod (capacity-1), or 0 with
// bad_capacity set when capacity is below 2. a lone last request with the
// empty flag is an empty string. the front keeps one request per cycle; each
// finished hash then waits in a two-entry queue for the back end, whose
// bit-serial remainder unit takes one quotient bit a cycle; per string it loads
// the hash, divides, then holds the response until taken. with the queue full,
// requests stall until the back end takes an entry. the user is to write
// capacity on the csr channel only while idle; the block does not enforce it.
`default_nettype none

module rotate_xor_string_hash_mod (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_char_code,
   input  wire logic        req_is_last,
   input  wire logic        req_is_empty,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [30:0]      rsp_hash_value,
   output logic             rsp_bad_capacity,
   // capacity write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [30:0] csr_capacity
);

   // capacity register, always ready for a write
   logic [rxh_pkg::CAP_WIDTH-1:0] capacity_ff, capacity_in;

   rxh_pkg::queue_status_type q_status;
   rxh_pkg::queue_entry_type  push_entry;
   rxh_pkg::queue_entry_type  pop_entry;
   logic                      q_push;
   logic                      q_pop;

   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_capacity : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= rxh_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // character absorption, one request a cycle while the queue is not full
   rxh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .req_is_empty  (req_is_empty),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   // finished hashes waiting for the remainder unit
   rxh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   // remainder unit and response register
   rxh_back u_back (
      .clock            (clock),
      .reset            (reset),
      .capacity         (capacity_ff),
      .q_status         (q_status),
      .q_entry          (pop_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_value   (rsp_hash_value),
      .rsp_bad_capacity (rsp_bad_capacity)
   );

endmodule

`default_nettype wire

[design/rxh_front.sv]
// front end: accepts characters and keeps the running rotate-xor hash
`default_nettype none

module rxh_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [15:0]                  req_char_code,
   input  wire logic                         req_is_last,
   input  wire logic                         req_is_empty,
   input  wire rxh_pkg::queue_status_type    q_status,
   output logic                              q_push,
   output rxh_pkg::queue_entry_type          q_entry
);

   logic [rxh_pkg::HASH_WIDTH-1:0] hash_ff;
   logic [rxh_pkg::HASH_WIDTH-1:0] hash_in;
   logic [rxh_pkg::HASH_WIDTH-1:0] char_masked;
   logic [rxh_pkg::HASH_WIDTH-1:0] absorbed;
   logic [rxh_pkg::HASH_WIDTH-1:0] final_hash;
   logic                           accept;

   assign req_ready   = !q_status.full;
   assign accept      = req_valid && req_ready;
   assign char_masked = rxh_pkg::HASH_WIDTH'(req_char_code) & rxh_pkg::CHAR_MASK;
   assign absorbed    = (hash_ff << rxh_pkg::SHIFT_LEFT) ^
                        (hash_ff >> rxh_pkg::SHIFT_RIGHT) ^ char_masked;

   // empty string sends the hash as it stands
   assign final_hash   = (req_is_last && req_is_empty) ? hash_ff : absorbed;
   assign q_push       = accept && req_is_last;
   assign q_entry.hash = final_hash;

   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         if (req_is_last) begin
            hash_in = '0;
         end else begin
            hash_in = absorbed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

`default_nettype wire

[design/rxh_queue.sv]
// short queue of finished string hashes between front and back
`default_nettype none

module rxh_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire rxh_pkg::queue_entry_type   push_entry,
   input  wire logic                       pop,
   output rxh_pkg::queue_entry_type        pop_entry,
   output rxh_pkg::queue_status_type       status
);

   localparam int CNT_W = $clog2(rxh_pkg::QUEUE_DEPTH + 1);

   rxh_pkg::queue_entry_type     mem_ff [rxh_pkg::QUEUE_DEPTH];
   logic [rxh_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rxh_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(rxh_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_entry    = mem_ff[rd_ptr_ff];

   function automatic logic [rxh_pkg::QUEUE_AW-1:0] ptr_next(
      input logic [rxh_pkg::QUEUE_AW-1:0] p);
      logic [rxh_pkg::QUEUE_AW-1:0] r;
      if (p == rxh_pkg::QUEUE_AW'(rxh_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[design/rxh_back.sv]
// back end: bit-serial remainder by capacity minus one and result register
`default_nettype none

module rxh_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [rxh_pkg::CAP_WIDTH-1:0]       capacity,
   input  wire rxh_pkg::queue_status_type           q_status,
   input  wire rxh_pkg::queue_entry_type            q_entry,
   output logic                                     q_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [30:0]                              rsp_hash_value,
   output logic                                     rsp_bad_capacity
);

   localparam int HW  = rxh_pkg::HASH_WIDTH;
   localparam int CW  = rxh_pkg::CAP_WIDTH;
   localparam int BCW = $clog2(HW);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

   back_state_type  state_ff, state_in;
   logic [HW-1:0]   dvd_ff, dvd_in;
   logic [CW-1:0]   rem_ff, rem_in;
   logic [CW-1:0]   div_ff, div_in;
   logic [BCW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]   res_ff, res_in;
   logic            bad_ff, bad_in;
   logic [CW:0]     rem_shift;
   logic            rem_ge;
   logic [CW-1:0]   rem_next;

   assign rem_shift = {rem_ff, dvd_ff[HW-1]};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});
   assign rem_next  = rem_ge ? CW'(rem_shift - {1'b0, div_ff}) : rem_shift[CW-1:0];

   assign q_pop            = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_hash_value   = res_ff;
   assign rsp_bad_capacity = bad_ff;

   always_comb begin
      state_in = state_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      bad_in   = bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               if (capacity < CW'(2)) begin
                  res_in   = '0;
                  bad_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  dvd_in   = q_entry.hash;
                  rem_in   = '0;
                  div_in   = capacity - 1'b1;
                  cnt_in   = BCW'(HW - 1);
                  bad_in   = 1'b0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = rem_next;
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               res_in   = rem_next;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      bad_ff <= bad_in;
   end

endmodule

`default_nettype wire

[design/rxh_checker.sv]
// port-level checker for the rotate-xor string hash block, with its bind
`default_nettype none
`include "rotate_xor_string_hash_mod_defines.svh"

module rxh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [30:0] rsp_hash_value,
   input wire logic        rsp_bad_capacity,
   input wire logic        csr_valid,
   input wire logic        csr_ready
);

   // stalled response holds
   `RXH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hash_value) && $stable(rsp_bad_capacity))

   // error response carries a zero hash
   `RXH_ASSERT_SAME(a_bad_zero, clock, reset, rsp_valid && rsp_bad_capacity, rsp_hash_value == 31'd0)

   // remainder is never all ones, as it stays below the largest modulus
   `RXH_ASSERT_SAME(a_rem_range, clock, reset, rsp_valid, rsp_hash_value != 31'h7FFF_FFFF)

   // no response right after reset
   `RXH_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

   // capacity writes never stall
   `RXH_ASSERT_SAME(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind rotate_xor_string_hash_mod rxh_checker u_rxh_checker (.*);

`default_nettype wire
